>>> rtl/rvp_pkg.sv
`default_nettype none
package rvp_pkg;

	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET_SIZE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_TYPE     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SSRC             = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEQUENCE = 8'd3;

	localparam logic [10:0] PKT_SIZE_MIN     = 11'd1037;
	localparam logic [10:0] PKT_SIZE_MAX     = 11'd1500;
	localparam logic [10:0] PKT_OVERHEAD     = 11'd13;
	localparam logic [10:0] MAX_PKT_RESET    = 11'd1400;
	localparam logic [6:0]  PAYLOAD_TYPE_RST = 7'd96;
	localparam logic [1:0]  HDR_VERSION      = 2'd2;
	localparam logic [7:0]  DESC_START       = 8'h08;
	localparam logic [7:0]  DESC_END         = 8'h04;

	typedef struct packed {
		logic [15:0] frame_length;
		logic [31:0] frame_timestamp;
	} rvp_in_t;

	typedef struct packed {
		logic [31:0] header_word0;
		logic [31:0] header_timestamp;
		logic [31:0] header_ssrc;
		logic [7:0]  descriptor_byte;
		logic [15:0] payload_offset;
		logic [10:0] payload_length;
		logic        last_packet;
	} rvp_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GEN,
		ST_EMIT
	} rvp_state_t;

	typedef struct packed {
		logic load;
		logic gen;
	} rvp_cmd_t;

	typedef struct packed {
		logic zero_len;
		logic done;
	} rvp_sts_t;

endpackage
`default_nettype wire

>>> rtl/rtp_vp9_packetizer_top.sv
// After a frame is accepted, the first packet is registered in ST_GEN and offered in ST_EMIT.
// Throughput: one packet per cycle while out_ready is high; an empty frame is accepted
// and dropped without emitting any packet.
// One frame is processed at a time; the remaining-length and offset registers track its progress.
// Reset clears the controller to idle, loads the register defaults, and zeroes the
// sequence number and the stored timestamp.
`default_nettype none
module rtp_vp9_packetizer_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire rvp_pkg::rvp_in_t              in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output rvp_pkg::rvp_out_t                  out_data,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [rvp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data
);
	import rvp_pkg::*;

	rvp_cmd_t cmd;
	rvp_sts_t sts;

	assign cfg_ready = 1'b1;

	rvp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rvp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("Frame request taken while packets are pending.");

	a_packets_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_data.last_packet) |=> out_valid)
		else $error("Gap between packets of one frame.");

	a_nonempty_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.payload_length != 11'd0))
		else $error("Packet with empty payload.");

	a_frame_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.last_packet) |=> (in_ready && !out_valid))
		else $error("Block not idle after the last packet.");

endmodule
`default_nettype wire

>>> rtl/rvp_ctrl.sv
`default_nettype none
module rvp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rvp_pkg::rvp_cmd_t     cmd,
	input  wire rvp_pkg::rvp_sts_t sts
);
	import rvp_pkg::*;

	rvp_state_t state_q;
	rvp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !sts.zero_len) begin
					state_d = ST_GEN;
				end
			end
			ST_GEN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready && sts.done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_GEN: begin
				cmd.gen = 1'b1;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.gen   = out_ready && !sts.done;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/rvp_dp.sv
`default_nettype none
module rvp_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rvp_pkg::rvp_in_t           in_data,
	output rvp_pkg::rvp_out_t               out_data,
	input  wire logic                       cfg_we,
	input  wire logic [rvp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                cfg_data,
	input  wire rvp_pkg::rvp_cmd_t          cmd,
	output rvp_pkg::rvp_sts_t               sts
);
	import rvp_pkg::*;

	logic [10:0] max_pkt_q;
	logic [6:0]  pt_q;
	logic [31:0] ssrc_q;
	logic [15:0] seq_q;
	logic [31:0] ts_q;
	logic [15:0] rem_q;
	logic [15:0] off_q;
	logic        first_q;
	logic [10:0] limit_q;
	rvp_out_t    out_q;

	logic [10:0] clamp_d;
	logic [10:0] limit_d;
	logic        last_d;
	logic [10:0] len_d;
	logic [7:0]  desc_d;

	always_comb begin
		clamp_d = max_pkt_q;
		if (max_pkt_q < PKT_SIZE_MIN) begin
			clamp_d = PKT_SIZE_MIN;
		end else if (max_pkt_q > PKT_SIZE_MAX) begin
			clamp_d = PKT_SIZE_MAX;
		end
		limit_d = clamp_d - PKT_OVERHEAD;
		last_d  = rem_q <= {5'd0, limit_q};
		len_d   = last_d ? rem_q[10:0] : limit_q;
		desc_d  = (first_q ? DESC_START : 8'h00) | (last_d ? DESC_END : 8'h00);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pkt_q <= MAX_PKT_RESET;
			pt_q      <= PAYLOAD_TYPE_RST;
			ssrc_q    <= '0;
			seq_q     <= '0;
			ts_q      <= '0;
			rem_q     <= '0;
			off_q     <= '0;
			first_q   <= 1'b0;
			limit_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_PACKET_SIZE:  max_pkt_q <= cfg_data[10:0];
					CFG_PAYLOAD_TYPE:     pt_q      <= cfg_data[6:0];
					CFG_SSRC:             ssrc_q    <= cfg_data;
					CFG_INITIAL_SEQUENCE: seq_q     <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				rem_q   <= in_data.frame_length;
				off_q   <= '0;
				first_q <= 1'b1;
				ts_q    <= in_data.frame_timestamp;
				limit_q <= limit_d;
			end
			if (cmd.gen) begin
				rem_q   <= rem_q - {5'd0, len_d};
				off_q   <= off_q + {5'd0, len_d};
				first_q <= 1'b0;
				seq_q   <= seq_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gen) begin
			out_q.header_word0     <= {HDR_VERSION, 6'd0, last_d, pt_q, seq_q};
			out_q.header_timestamp <= ts_q;
			out_q.header_ssrc      <= ssrc_q;
			out_q.descriptor_byte  <= desc_d;
			out_q.payload_offset   <= off_q;
			out_q.payload_length   <= len_d;
			out_q.last_packet      <= last_d;
		end
	end

	assign out_data     = out_q;
	assign sts.zero_len = in_data.frame_length == 16'd0;
	assign sts.done     = rem_q == 16'd0;

endmodule
`default_nettype wire
